/* hdl/tgad_pkg.sv */
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; used by every module under hdl/.
package tgad_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RLE_ENABLE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIRROR_COLUMNS = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP_ORIGIN     = 3'd5;

    // pixel format codes; the unused code decodes as BGRA
    localparam logic [1:0] FMT_MONO = 2'd0;
    localparam logic [1:0] FMT_BGR  = 2'd1;
    localparam logic [1:0] FMT_BGRA = 2'd2;

    // packet header byte
    localparam int         HDR_RUN_BIT    = 7;
    localparam logic [6:0] HDR_COUNT_MASK = 7'h7f;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic        rle_enable;
        logic [15:0] row_width;
        logic [15:0] image_height;
        logic        mirror_columns;
        logic        top_origin;
    } cfg_t;

    // one classified beat between front and back
    typedef struct packed {
        logic        err;
        logic        last;
        logic [23:0] hold;
        logic [7:0]  pix_byte;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0]  length;
    } span_item_t;

    // index of the byte that completes a pixel
    function automatic logic [1:0] last_slot(input logic [1:0] fmt);
        logic [1:0] slot;
        if (fmt[1])
            slot = 2'd3;
        else if (fmt == FMT_BGR)
            slot = 2'd2;
        else
            slot = 2'd0;
        return slot;
    endfunction

endpackage

/* hdl/tgad_front.sv */
// Front end: takes data bytes, tracks packet, pixel-assembly and position state.
// Emits one span_item_t per finished pixel/run or packet error. Uses tgad_pkg.
module tgad_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgad_pkg::cfg_t       cfg,
    input  logic                 push,
    input  logic [7:0]           data_byte,
    input  logic                 image_start,
    input  logic                 q_full,
    output logic                 q_push,
    output tgad_pkg::span_item_t q_item
);

    logic        expect_header_reg, expect_header_next;
    logic        run_packet_reg, run_packet_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic [1:0]  byte_slot_reg, byte_slot_next;
    logic [23:0] pixel_hold_reg, pixel_hold_next;
    logic [15:0] column_pos_reg, column_pos_next;
    logic [15:0] row_pos_reg, row_pos_next;
    logic        halted_reg, halted_next;

    logic        in_fire;
    logic        cur_expect, cur_run, cur_halted;
    logic [7:0]  cur_left;
    logic [1:0]  cur_slot;
    logic [23:0] cur_hold;
    logic [15:0] cur_col, cur_row;
    logic [7:0]  count;
    logic [16:0] hdr_sum;
    logic [7:0]  len;
    logic [16:0] col_sum;
    logic [15:0] row_inc;
    logic        item_valid;

    assign in_fire = push && !q_full;

    // image start clears position state before the byte is taken
    assign cur_expect = image_start ? 1'b1  : expect_header_reg;
    assign cur_run    = image_start ? 1'b0  : run_packet_reg;
    assign cur_left   = image_start ? 8'd0  : packet_left_reg;
    assign cur_slot   = image_start ? 2'd0  : byte_slot_reg;
    assign cur_hold   = image_start ? 24'd0 : pixel_hold_reg;
    assign cur_col    = image_start ? 16'd0 : column_pos_reg;
    assign cur_row    = image_start ? 16'd0 : row_pos_reg;
    assign cur_halted = image_start ? 1'b0  : halted_reg;

    assign count   = {1'b0, data_byte[6:0] & tgad_pkg::HDR_COUNT_MASK} + 8'd1;
    assign hdr_sum = {1'b0, cur_col} + {9'd0, count};

    always_comb
    begin
        len = (cfg.rle_enable && cur_run) ? cur_left : 8'd1;
        if (len == 8'd0)
        begin
            len = 8'd1;
        end
    end

    assign col_sum = {1'b0, cur_col} + {9'd0, len};
    assign row_inc = cur_row + 16'd1;

    always_comb
    begin
        expect_header_next = cur_expect;
        run_packet_next    = cur_run;
        packet_left_next   = cur_left;
        byte_slot_next     = cur_slot;
        pixel_hold_next    = cur_hold;
        column_pos_next    = cur_col;
        row_pos_next       = cur_row;
        halted_next        = cur_halted;
        item_valid         = 1'b0;
        q_item             = '0;
        q_item.hold        = cur_hold;
        q_item.pix_byte    = data_byte;
        q_item.column      = cur_col;
        q_item.row         = cur_row;
        q_item.length      = len;

        if (cur_halted || (cur_row >= cfg.image_height))
        begin
            // beat dropped
        end
        else if (cfg.rle_enable && cur_expect)
        begin
            if (hdr_sum > {1'b0, cfg.row_width})
            begin
                halted_next = 1'b1;
                item_valid  = 1'b1;
                q_item      = '0;
                q_item.err  = 1'b1;
            end
            else
            begin
                run_packet_next    = data_byte[tgad_pkg::HDR_RUN_BIT];
                packet_left_next   = count;
                byte_slot_next     = 2'd0;
                pixel_hold_next    = 24'd0;
                expect_header_next = 1'b0;
            end
        end
        else if (cur_slot < tgad_pkg::last_slot(cfg.pixel_format))
        begin
            case (cur_slot)
                2'd0:    pixel_hold_next[7:0]   = cur_hold[7:0]   | data_byte;
                2'd1:    pixel_hold_next[15:8]  = cur_hold[15:8]  | data_byte;
                2'd2:    pixel_hold_next[23:16] = cur_hold[23:16] | data_byte;
                default: pixel_hold_next        = cur_hold;
            endcase
            byte_slot_next = cur_slot + 2'd1;
        end
        else
        begin
            item_valid      = 1'b1;
            byte_slot_next  = 2'd0;
            pixel_hold_next = 24'd0;
            if (cfg.rle_enable)
            begin
                packet_left_next = (cur_left >= len) ? (cur_left - len) : 8'd0;
                if (packet_left_next == 8'd0)
                begin
                    expect_header_next = 1'b1;
                end
            end
            if (col_sum >= {1'b0, cfg.row_width})
            begin
                column_pos_next = 16'd0;
                if (row_inc >= cfg.image_height)
                begin
                    q_item.last  = 1'b1;
                    row_pos_next = cfg.image_height;
                end
                else
                begin
                    row_pos_next = row_inc;
                end
            end
            else
            begin
                column_pos_next = col_sum[15:0];
            end
        end
    end

    assign q_push = in_fire && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            run_packet_reg    <= 1'b0;
            packet_left_reg   <= 8'd0;
            byte_slot_reg     <= 2'd0;
            pixel_hold_reg    <= 24'd0;
            column_pos_reg    <= 16'd0;
            row_pos_reg       <= 16'd0;
            halted_reg        <= 1'b0;
        end
        else if (in_fire)
        begin
            expect_header_reg <= expect_header_next;
            run_packet_reg    <= run_packet_next;
            packet_left_reg   <= packet_left_next;
            byte_slot_reg     <= byte_slot_next;
            pixel_hold_reg    <= pixel_hold_next;
            column_pos_reg    <= column_pos_next;
            row_pos_reg       <= row_pos_next;
            halted_reg        <= halted_next;
        end
    end

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_item.err |=> halted_reg)
        else $error("packet error did not halt the front end");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_item.last |=> column_pos_reg == 16'd0)
        else $error("image end left a nonzero column");

endmodule

/* hdl/tgad_fifo.sv */
// Short register queue between the front and back ends.
// Carries tgad_pkg::span_item_t beats; depth set by DEPTH.
module tgad_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tgad_pkg::span_item_t item_in,
    output logic                 full,
    input  logic                 pop,
    output tgad_pkg::span_item_t item_out,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tgad_pkg::span_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign item_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

/* hdl/tgad_back.sv */
// Back end: turns queued beats into destination spans (mirroring, row flip,
// channel regrouping) and holds the result register. Uses tgad_pkg.
module tgad_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgad_pkg::cfg_t       cfg,
    input  logic                 q_empty,
    input  tgad_pkg::span_item_t q_item,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           chan_red,
    output logic [7:0]           chan_green,
    output logic [7:0]           chan_blue,
    output logic [7:0]           chan_alpha,
    output logic [15:0]          span_column,
    output logic [15:0]          span_row,
    output logic [7:0]           span_length,
    output logic                 image_last,
    output logic                 packet_error
);

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic [7:0]  red_next, green_next, blue_next, alpha_next;
    logic [15:0] column_reg, column_next;
    logic [15:0] row_reg, row_next;
    logic [7:0]  length_reg, length_next;
    logic        last_reg, last_next;
    logic        error_reg, error_next;

    assign q_pop = !q_empty && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        red_next    = 8'd0;
        green_next  = 8'd0;
        blue_next   = 8'd0;
        alpha_next  = 8'd0;
        column_next = 16'd0;
        row_next    = 16'd0;
        length_next = 8'd0;
        last_next   = 1'b0;
        error_next  = q_item.err;
        if (!q_item.err)
        begin
            if (cfg.pixel_format[1])
            begin
                blue_next  = q_item.hold[7:0];
                green_next = q_item.hold[15:8];
                red_next   = q_item.hold[23:16];
                alpha_next = q_item.pix_byte;
            end
            else if (cfg.pixel_format == tgad_pkg::FMT_BGR)
            begin
                blue_next  = q_item.hold[7:0];
                green_next = q_item.hold[15:8];
                red_next   = q_item.pix_byte;
            end
            else
            begin
                red_next = q_item.pix_byte;
            end
            if (cfg.mirror_columns)
                column_next = cfg.row_width - q_item.column - {8'd0, q_item.length};
            else
                column_next = q_item.column;
            if (cfg.top_origin)
                row_next = q_item.row;
            else
                row_next = cfg.image_height - 16'd1 - q_item.row;
            length_next = q_item.length;
            last_next   = q_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            alpha_reg  <= alpha_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            length_reg <= length_next;
            last_reg   <= last_next;
            error_reg  <= error_next;
        end
    end

    assign empty        = !out_valid_reg;
    assign chan_red     = red_reg;
    assign chan_green   = green_reg;
    assign chan_blue    = blue_reg;
    assign chan_alpha   = alpha_reg;
    assign span_column  = column_reg;
    assign span_row     = row_reg;
    assign span_length  = length_reg;
    assign image_last   = last_reg;
    assign packet_error = error_reg;

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && error_reg |-> length_reg == 8'd0 && !last_reg)
        else $error("error beat carries span data");

endmodule

/* hdl/tga_rle_pixel_decoder.sv */
// Top level of the TGA run-length pixel decoder: configuration registers,
// front end, beat queue and back end. Uses tgad_pkg, tgad_front, tgad_fifo, tgad_back.
//
// Takes one pixel-data byte per clock (push/full) while full is low, and gives one
// span per finished pixel or run (empty/pop), or one error beat when a packet overruns
// its row. An accepted byte's span passes through the beat queue and then the output
// register; the sustained rate is one byte per cycle while neither side stalls, set
// by the front end's packet and position update. QUEUE_DEPTH beats of slack sit between
// front and back ends, plus the output register. The user must write configuration
// through cfg_wr_en/cfg_addr/cfg_wdata only while the block is idle (left unchecked).
module tga_rle_pixel_decoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      data_byte,
    input  logic                            image_start,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      chan_red,
    output logic [7:0]                      chan_green,
    output logic [7:0]                      chan_blue,
    output logic [7:0]                      chan_alpha,
    output logic [15:0]                     span_column,
    output logic [15:0]                     span_row,
    output logic [7:0]                      span_length,
    output logic                            image_last,
    output logic                            packet_error,
    input  logic                            cfg_wr_en,
    input  logic [tgad_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tgad_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    tgad_pkg::cfg_t       cfg_reg;
    tgad_pkg::span_item_t front_item, back_item;
    logic                 q_push, q_full, q_pop, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format   <= tgad_pkg::FMT_BGR;
            cfg_reg.rle_enable     <= 1'b1;
            cfg_reg.row_width      <= 16'd1;
            cfg_reg.image_height   <= 16'd1;
            cfg_reg.mirror_columns <= 1'b0;
            cfg_reg.top_origin     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                tgad_pkg::REG_PIXEL_FORMAT:   cfg_reg.pixel_format   <= cfg_wdata[1:0];
                tgad_pkg::REG_RLE_ENABLE:     cfg_reg.rle_enable     <= cfg_wdata[0];
                tgad_pkg::REG_ROW_WIDTH:      cfg_reg.row_width      <= cfg_wdata;
                tgad_pkg::REG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_wdata;
                tgad_pkg::REG_MIRROR_COLUMNS: cfg_reg.mirror_columns <= cfg_wdata[0];
                tgad_pkg::REG_TOP_ORIGIN:     cfg_reg.top_origin     <= cfg_wdata[0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign full = q_full;

    tgad_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .data_byte   (data_byte),
        .image_start (image_start),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (front_item)
    );

    tgad_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (front_item),
        .full     (q_full),
        .pop      (q_pop),
        .item_out (back_item),
        .empty    (q_empty)
    );

    tgad_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_item       (back_item),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .chan_red     (chan_red),
        .chan_green   (chan_green),
        .chan_blue    (chan_blue),
        .chan_alpha   (chan_alpha),
        .span_column  (span_column),
        .span_row     (span_row),
        .span_length  (span_length),
        .image_last   (image_last),
        .packet_error (packet_error)
    );

endmodule

/* dv/tb_tga_rle_pixel_decoder.sv */
`timescale 1ns / 1ps
// Self-checking testbench for tga_rle_pixel_decoder: streams TGA pixel-data bytes,
// predicts each span or overrun beat, and checks every popped beat in order.
// Depends on hdl/tgad_pkg.sv and the decoder RTL under hdl/.
module tb_tga_rle_pixel_decoder;

    localparam int ITEMS        = 450;
    localparam int LIMIT        = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [1:0] FMT_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0]  length;
        logic        last;
        logic        err;
    } span_t;

    // Decoder predictor plus the queue of spans it still expects.
    class span_board;
        logic [1:0]  cfg_fmt;
        bit          cfg_rle;
        int unsigned cfg_width;
        int unsigned cfg_height;
        bit          cfg_mirror;
        bit          cfg_top;

        bit          want_hdr;
        bit          in_run;
        int unsigned pix_left;
        int unsigned slot;
        logic [23:0] hold;
        int unsigned col_pos;
        int unsigned row_pos;
        bit          stopped;

        span_t       expected_spans[$];
        int          errors;
        int          beats_checked;

        function new();
            cfg_fmt    = tgad_pkg::FMT_BGR;
            cfg_rle    = 1;
            cfg_width  = 1;
            cfg_height = 1;
            cfg_mirror = 0;
            cfg_top    = 0;
            errors     = 0;
            beats_checked = 0;
            clear_position();
        endfunction

        function void clear_position();
            want_hdr = 1;
            in_run   = 0;
            pix_left = 0;
            slot     = 0;
            hold     = '0;
            col_pos  = 0;
            row_pos  = 0;
            stopped  = 0;
        endfunction

        function void set_reg(logic [tgad_pkg::CFG_ADDR_W-1:0] idx,
                              logic [tgad_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                tgad_pkg::REG_PIXEL_FORMAT:   cfg_fmt    = val[1:0];
                tgad_pkg::REG_RLE_ENABLE:     cfg_rle    = val[0];
                tgad_pkg::REG_ROW_WIDTH:      cfg_width  = 32'(val);
                tgad_pkg::REG_IMAGE_HEIGHT:   cfg_height = 32'(val);
                tgad_pkg::REG_MIRROR_COLUMNS: cfg_mirror = val[0];
                tgad_pkg::REG_TOP_ORIGIN:     cfg_top    = val[0];
                default: ;
            endcase
        endfunction

        // spare format code decodes as BGRA
        function int unsigned bytes_per_pixel();
            return cfg_fmt[1] ? 4 : (cfg_fmt == tgad_pkg::FMT_BGR) ? 3 : 1;
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            span_t       s;
            int unsigned bpp;
            int unsigned cnt;
            int unsigned len;
            if (start)
                clear_position();
            if (stopped || row_pos >= cfg_height)
                return;
            if (cfg_rle && want_hdr)
            begin
                cnt = 32'(b[6:0] & tgad_pkg::HDR_COUNT_MASK);
                cnt = cnt + 1;
                if (col_pos + cnt > cfg_width)
                begin
                    stopped = 1;
                    s = '0;
                    s.err = 1'b1;
                    expected_spans.push_back(s);
                    return;
                end
                in_run   = b[tgad_pkg::HDR_RUN_BIT];
                pix_left = cnt;
                slot     = 0;
                hold     = '0;
                want_hdr = 0;
                return;
            end
            bpp = bytes_per_pixel();
            if (slot + 1 < bpp)
            begin
                hold[8*slot +: 8] = b;
                slot++;
                return;
            end
            s = '0;
            case (bpp)
                1: s.red = b;
                3:
                begin
                    s.blue  = hold[7:0];
                    s.green = hold[15:8];
                    s.red   = b;
                end
                default:
                begin
                    s.blue  = hold[7:0];
                    s.green = hold[15:8];
                    s.red   = hold[23:16];
                    s.alpha = b;
                end
            endcase
            slot = 0;
            hold = '0;
            len = (cfg_rle && in_run) ? pix_left : 1;
            if (len == 0)
                len = 1;
            s.column = cfg_mirror ? 16'(cfg_width - col_pos - len) : 16'(col_pos);
            s.row    = cfg_top ? 16'(row_pos) : 16'(cfg_height - 1 - row_pos);
            s.length = 8'(len);
            if (cfg_rle)
            begin
                pix_left = (pix_left >= len) ? pix_left - len : 0;
                if (pix_left == 0)
                    want_hdr = 1;
            end
            col_pos = col_pos + len;
            if (col_pos >= cfg_width)
            begin
                col_pos = 0;
                row_pos = (row_pos + 1) & 32'hffff;
                if (row_pos >= cfg_height)
                begin
                    s.last  = 1'b1;
                    row_pos = cfg_height;
                end
            end
            col_pos = col_pos & 32'hffff;
            expected_spans.push_back(s);
        endfunction

        task report_mismatch(string msg);
            if (errors < 50)
                $display("mismatch at beat %0d: %s", beats_checked, msg);
            errors++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_span(span_t got);
            span_t want;
            if (expected_spans.size() == 0)
            begin
                report_mismatch($sformatf("beat with nothing expected: %h", got));
                return;
            end
            want = expected_spans.pop_front();
            compare_field("chan_red", 16'(got.red), 16'(want.red));
            compare_field("chan_green", 16'(got.green), 16'(want.green));
            compare_field("chan_blue", 16'(got.blue), 16'(want.blue));
            compare_field("chan_alpha", 16'(got.alpha), 16'(want.alpha));
            compare_field("span_column", got.column, want.column);
            compare_field("span_row", got.row, want.row);
            compare_field("span_length", 16'(got.length), 16'(want.length));
            compare_field("image_last", 16'(got.last), 16'(want.last));
            compare_field("packet_error", 16'(got.err), 16'(want.err));
            beats_checked++;
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            pop = 1'b0;
    logic [7:0]                      data_byte = '0;
    logic                            image_start = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [tgad_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [tgad_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic        full;
    logic        empty;
    logic [7:0]  chan_red;
    logic [7:0]  chan_green;
    logic [7:0]  chan_blue;
    logic [7:0]  chan_alpha;
    logic [15:0] span_column;
    logic [15:0] span_row;
    logic [7:0]  span_length;
    logic        image_last;
    logic        packet_error;

    span_board board;
    int        idle_pct = 22;
    int        sent = 0;
    int        cycles = 0;
    bit        held_off = 0;

    tga_rle_pixel_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .image_start  (image_start),
        .empty        (empty),
        .pop          (pop),
        .chan_red     (chan_red),
        .chan_green   (chan_green),
        .chan_blue    (chan_blue),
        .chan_alpha   (chan_alpha),
        .span_column  (span_column),
        .span_row     (span_row),
        .span_length  (span_length),
        .image_last   (image_last),
        .packet_error (packet_error),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
        pop <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
        if (rst_n && push && full === 1'b0)
            board.take_byte(data_byte, image_start);

    always @(posedge clk)
    begin : span_monitor
        span_t got;
        if (rst_n && pop && empty === 1'b0)
        begin
            got.red    = chan_red;
            got.green  = chan_green;
            got.blue   = chan_blue;
            got.alpha  = chan_alpha;
            got.column = span_column;
            got.row    = span_row;
            got.length = span_length;
            got.last   = image_last;
            got.err    = packet_error;
            board.check_span(got);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic first);
        idle_pct = (sent >= 180 && sent < 280) ? 0 : 22;
        if (!held_off && sent == 120)
        begin
            // hold the sender off until the result side has caught up
            held_off = 1;
            push <= 1'b0;
            @(posedge clk);
            while (board.pending() != 0)
                @(posedge clk);
        end
        else if ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= value;
        image_start <= first;
        do
            @(posedge clk);
        while (full !== 1'b0);
        sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        // bytes that make no beat may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [tgad_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [tgad_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic write_regs(input logic [1:0] fmt, input bit rle, input logic [15:0] width,
                              input logic [15:0] height, input bit mirror, input bit top);
        drain();
        put_reg(tgad_pkg::REG_PIXEL_FORMAT, 16'(fmt));
        put_reg(tgad_pkg::REG_RLE_ENABLE, 16'(rle));
        put_reg(tgad_pkg::REG_ROW_WIDTH, width);
        put_reg(tgad_pkg::REG_IMAGE_HEIGHT, height);
        put_reg(tgad_pkg::REG_MIRROR_COLUMNS, 16'(mirror));
        put_reg(tgad_pkg::REG_TOP_ORIGIN, 16'(top));
        cfg_wr_en <= 1'b0;
    endtask

    // One image under the current settings; a broken one may be cut short or
    // carry a packet that overruns its row.
    task automatic send_image(input bit broken);
        int unsigned row;
        int unsigned col;
        int unsigned room;
        int unsigned cnt;
        int unsigned npix;
        int unsigned bpp;
        logic        run;
        logic        first;
        first = 1'b1;
        bpp = board.bytes_per_pixel();
        for (row = 0; row < board.cfg_height; row++)
        begin
            col = 0;
            while (col < board.cfg_width)
            begin
                if (sent >= ITEMS || (broken && $urandom_range(11) == 0))
                    return;
                room = board.cfg_width - col;
                cnt  = 1;
                npix = 1;
                if (board.cfg_rle)
                begin
                    run = (board.cfg_width > 16) ? ($urandom_range(9) != 0)
                                                 : 1'($urandom_range(1));
                    cnt = $urandom_range(room > 128 ? 128 : room, 1);
                    if (!run && cnt > 12)
                        cnt = $urandom_range(12, 1);
                    if (broken && room < 128 && $urandom_range(3) == 0)
                        cnt = $urandom_range(128, room + 1);
                    send_byte({run, 7'(cnt - 1)}, first);
                    first = 1'b0;
                    if (cnt > room)
                        return;
                    npix = run ? 1 : cnt;
                end
                repeat (npix * bpp)
                begin
                    send_byte(8'($urandom), first);
                    first = 1'b0;
                end
                col += cnt;
            end
        end
    endtask

    initial
    begin : stimulus
        bit big;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one BGR run fills the 1x1 image, then a byte past the end
        send_byte(8'h80, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'hc3, 1'b0);

        // mono, mirrored, bottom-up: run, raw packet, overrun, then halted
        write_regs(tgad_pkg::FMT_MONO, 1, 16'd4, 16'd2, 1, 0);
        send_byte(8'h83, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h55, 1'b0);

        // spare format code, raw pixels, zero width: every pixel ends a row
        write_regs(FMT_SPARE, 0, 16'd0, 16'd3, 0, 1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'hfe, 1'b0);
        send_byte(8'hfd, 1'b0);
        send_byte(8'hfb, 1'b0);
        send_byte(8'hf7, 1'b0);

        // widest settings with the longest run
        write_regs(tgad_pkg::FMT_BGRA, 1, 16'hffff, 16'hffff, 1, 0);
        send_byte(8'hff, 1'b1);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);

        // zero width under packet coding: first header overruns
        write_regs(tgad_pkg::FMT_MONO, 1, 16'd0, 16'd1, 0, 0);
        send_byte(8'h00, 1'b1);

        // zero height: nothing comes out
        write_regs(tgad_pkg::FMT_BGR, 0, 16'd3, 16'd0, 0, 1);
        send_byte(8'h7f, 1'b1);

        while (sent < ITEMS)
        begin
            big = ($urandom_range(9) == 0);
            write_regs(2'($urandom_range(3)),
                       big ? 1'b1 : ($urandom_range(9) < 7),
                       big ? 16'($urandom_range(140, 100)) : 16'($urandom_range(10, 1)),
                       big ? 16'd1 : 16'($urandom_range(4, 1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
            repeat ($urandom_range(3, 1))
            begin
                send_image($urandom_range(7) == 0);
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(6, 1))
                        send_byte(8'($urandom), $urandom_range(5) == 0);
            end
        end

        drain();
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d beats never came", board.pending()));
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
